// ----- src/tksi_pkg.sv -----
// Shared types, constants and field widths of the top-k sorted insert table.
package tksi_pkg;

  // Default sizing of the table.
  localparam int unsigned CapacityDef = 16;
  localparam int unsigned TagBitsDef  = 16;

  // Field widths of the item channels and the limit register.
  localparam int unsigned ScoreW = 32;
  localparam int unsigned TagW   = 16;
  localparam int unsigned RankW  = 4;
  localparam int unsigned CountW = 5;
  localparam int unsigned LimitW = 5;

  // Limit that the table starts with after reset.
  localparam logic [LimitW-1:0] LimitReset = LimitW'(10);

  // Item kinds.
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_READ   = 1'b1
  } item_kind_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_OUT
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the accepted item
    logic exec;  // run the compare and shift, register the result
  } ctl_cmd_t;

endpackage

// ----- src/tksi_in_if.sv -----
// Input item channel: valid, ready and the insert or read request.
interface tksi_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   kind;
  logic signed [tksi_pkg::ScoreW-1:0]     new_score;
  logic        [tksi_pkg::TagW-1:0]       new_tag;
  logic        [tksi_pkg::RankW-1:0]      read_rank;

  modport source (output valid, kind, new_score, new_tag, read_rank, input ready);
  modport sink   (input valid, kind, new_score, new_tag, read_rank, output ready);
endinterface

// ----- src/tksi_out_if.sv -----
// Result item channel: valid, ready and the outcome of one item.
interface tksi_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   accepted;
  logic        [tksi_pkg::RankW-1:0]      placed_rank;
  logic        [tksi_pkg::CountW-1:0]     entry_count;
  logic                                   read_valid;
  logic signed [tksi_pkg::ScoreW-1:0]     read_score;
  logic        [tksi_pkg::TagW-1:0]       read_tag;

  modport source (output valid, accepted, placed_rank, entry_count, read_valid,
                  read_score, read_tag, input ready);
  modport sink   (input valid, accepted, placed_rank, entry_count, read_valid,
                  read_score, read_tag, output ready);
endinterface

// ----- src/tksi_ctrl.sv -----
// Controller state machine sequencing capture, execution and result handoff.
module tksi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output tksi_pkg::ctl_cmd_t cmd_o
);

  tksi_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tksi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      tksi_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tksi_pkg::ST_CALC;
        end
      end
      tksi_pkg::ST_CALC: begin
        cmd_o.exec = 1'b1;
        state_d    = tksi_pkg::ST_OUT;
      end
      tksi_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        // The next item may enter in the cycle the waiting result is taken.
        in_ready_o  = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = tksi_pkg::ST_CALC;
          end else begin
            state_d = tksi_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = tksi_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // A captured item is always executed in the following cycle.
  a_load_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.exec)
    else $error("captured item was not executed next cycle");

  // Execution always presents a result in the next cycle.
  a_exec_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o)
    else $error("execution did not produce a result");
`endif

endmodule

// ----- src/tksi_datapath.sv -----
// Datapath: sorted slot registers, per-slot compare and shift, read mux, result register.
module tksi_datapath #(
  parameter int unsigned CAPACITY = tksi_pkg::CapacityDef,
  parameter int unsigned TAG_BITS = tksi_pkg::TagBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tksi_pkg::ctl_cmd_t                   cmd_i,
  input  logic                                 cfg_we_i,
  input  logic        [tksi_pkg::LimitW-1:0]   cfg_wdata_i,
  input  logic                                 kind_i,
  input  logic signed [tksi_pkg::ScoreW-1:0]   new_score_i,
  input  logic        [tksi_pkg::TagW-1:0]     new_tag_i,
  input  logic        [tksi_pkg::RankW-1:0]    read_rank_i,
  output logic                                 accepted_o,
  output logic        [tksi_pkg::RankW-1:0]    placed_rank_o,
  output logic        [tksi_pkg::CountW-1:0]   entry_count_o,
  output logic                                 read_valid_o,
  output logic signed [tksi_pkg::ScoreW-1:0]   read_score_o,
  output logic        [tksi_pkg::TagW-1:0]     read_tag_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned WW = (CW > tksi_pkg::LimitW) ? CW : tksi_pkg::LimitW;
  localparam int unsigned TB = (TAG_BITS < tksi_pkg::TagW) ? TAG_BITS : tksi_pkg::TagW;

  // Clamp a written limit to the range one to CAPACITY.
  function automatic logic [CW-1:0] eff_limit(input logic [tksi_pkg::LimitW-1:0] lim);
    logic [WW-1:0] wide;
    wide = WW'(lim);
    if (lim == '0) begin
      return CW'(1);
    end else if (wide > WW'(CAPACITY)) begin
      return CW'(CAPACITY);
    end
    return CW'(lim);
  endfunction

  // Captured item.
  logic                               kind_q;
  logic signed [tksi_pkg::ScoreW-1:0] score_q;
  logic        [TB-1:0]               tag_q;
  logic        [tksi_pkg::RankW-1:0]  rrank_q;

  // Table state.
  logic        [tksi_pkg::LimitW-1:0] limit_q, limit_d;
  logic        [CW-1:0]               count_q, count_d;
  logic signed [tksi_pkg::ScoreW-1:0] slot_score_q [CAPACITY];
  logic signed [tksi_pkg::ScoreW-1:0] slot_score_d [CAPACITY];
  logic        [TB-1:0]               slot_tag_q   [CAPACITY];
  logic        [TB-1:0]               slot_tag_d   [CAPACITY];

  logic [CAPACITY-1:0] keep;
  logic [CW-1:0]       lim_now;
  logic [CW-1:0]       rank;
  logic                is_insert;
  logic                do_insert;

  logic                               rvalid;
  logic signed [tksi_pkg::ScoreW-1:0] rscore;
  logic        [TB-1:0]               rtag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      score_q <= new_score_i;
      tag_q   <= new_tag_i[TB-1:0];
      rrank_q <= read_rank_i;
    end
  end

  assign lim_now   = eff_limit(limit_q);
  assign is_insert = (kind_q == tksi_pkg::KIND_INSERT);

  // A slot keeps its entry when it is held and scores at least the new one.
  // Since the table is sorted these slots form a prefix.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      keep[i] = (32'(count_q) > i) && (slot_score_q[i] >= score_q);
    end
  end

  always_comb begin
    rank = CW'(CAPACITY);
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!keep[i]) begin
        rank = CW'(i);
      end
    end
  end

  assign do_insert = cmd_i.exec && is_insert && (rank < lim_now);

  // Each slot either keeps its entry, takes the new one, or takes its upper neighbor's.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
    if (g == 0) begin : g_top
      always_comb begin
        slot_score_d[g] = keep[g] ? slot_score_q[g] : score_q;
        slot_tag_d[g]   = keep[g] ? slot_tag_q[g]   : tag_q;
      end
    end else begin : g_rest
      always_comb begin
        if (keep[g]) begin
          slot_score_d[g] = slot_score_q[g];
          slot_tag_d[g]   = slot_tag_q[g];
        end else if (keep[g-1]) begin
          slot_score_d[g] = score_q;
          slot_tag_d[g]   = tag_q;
        end else begin
          slot_score_d[g] = slot_score_q[g-1];
          slot_tag_d[g]   = slot_tag_q[g-1];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (do_insert) begin
        slot_score_q[g] <= slot_score_d[g];
        slot_tag_q[g]   <= slot_tag_d[g];
      end
    end
  end

  // Limit register and entry count; a lowered limit drops the lowest entries at once.
  always_comb begin
    limit_d = limit_q;
    count_d = count_q;
    if (cfg_we_i) begin
      limit_d = cfg_wdata_i;
      if (count_q > eff_limit(cfg_wdata_i)) begin
        count_d = eff_limit(cfg_wdata_i);
      end
    end else if (do_insert && (count_q < lim_now)) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= tksi_pkg::LimitReset;
      count_q <= '0;
    end else begin
      limit_q <= limit_d;
      count_q <= count_d;
    end
  end

  // Read path.
  always_comb begin
    rvalid = !is_insert && (32'(rrank_q) < 32'(count_q));
    rscore = '0;
    rtag   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rvalid && (32'(rrank_q) == i)) begin
        rscore = slot_score_q[i];
        rtag   = slot_tag_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      accepted_o    <= do_insert;
      placed_rank_o <= do_insert ? tksi_pkg::RankW'(rank) : '0;
      entry_count_o <= tksi_pkg::CountW'(count_d);
      read_valid_o  <= rvalid;
      read_score_o  <= rscore;
      read_tag_o    <= tksi_pkg::TagW'(rtag);
    end
  end

`ifndef NO_ASSERTIONS
  // The table never holds more entries than the current limit allows.
  a_count_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lim_now)
    else $error("entry count exceeds the effective limit");

  // The count moves only on an executed item or a limit write.
  a_count_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.exec || cfg_we_i) |=> $stable(count_q))
    else $error("entry count changed without cause");

  // An insert grows the table by at most one entry.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && !cfg_we_i) |=> (32'(count_q) <= 32'($past(count_q)) + 32'd1))
    else $error("entry count grew by more than one");
`endif

endmodule

// ----- src/top_k_sorted_insert_table_unit.sv -----
// Top level of the top-k sorted insert table: controller, datapath and channel wiring.
//
//   channel   direction  handshake            contents
//   in_if     in         valid / ready        kind, new_score, new_tag, read_rank
//   out_if    out        valid / ready        accepted, placed_rank, entry_count,
//                                             read_valid, read_score, read_tag
//   cfg       in         cfg_we_i (no ready)  table_limit in cfg_wdata_i
//
// An item is captured at acceptance, then the execute state runs the compare and shift over
// all slots in parallel and registers the result, which is shown in the following cycle.
// The capture register and the execute state of the slot array serve one item at a time,
// so the unit takes no new item before the result of the last one is taken, also with a
// sink that is always ready.
// A stalled result holds its value until taken; the next item is accepted in the cycle
// the result leaves. Reset clears the controller, the entry count and sets the limit to
// ten; slot contents are left unset and are never read beyond the count.
module top_k_sorted_insert_table_unit #(
  parameter int unsigned CAPACITY = tksi_pkg::CapacityDef,
  parameter int unsigned TAG_BITS = tksi_pkg::TagBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tksi_pkg::LimitW-1:0]   cfg_wdata_i,
  tksi_in_if.sink                       in_if,
  tksi_out_if.source                    out_if
);

  tksi_pkg::ctl_cmd_t cmd;

  // The controller owns the handshakes and tells the datapath when to capture and run.
  tksi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .out_ready_i (out_if.ready),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .cmd_o       (cmd)
  );

  // The datapath holds the sorted slots, the limit and count, and the result register.
  tksi_datapath #(
    .CAPACITY (CAPACITY),
    .TAG_BITS (TAG_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .kind_i        (in_if.kind),
    .new_score_i   (in_if.new_score),
    .new_tag_i     (in_if.new_tag),
    .read_rank_i   (in_if.read_rank),
    .accepted_o    (out_if.accepted),
    .placed_rank_o (out_if.placed_rank),
    .entry_count_o (out_if.entry_count),
    .read_valid_o  (out_if.read_valid),
    .read_score_o  (out_if.read_score),
    .read_tag_o    (out_if.read_tag)
  );

endmodule
